FILE: hw/rtl/accumulator_alu_with_memory_top_defines.svh
// Assertion macros used by the checker of the accumulator block.
`ifndef ACCUMULATOR_ALU_WITH_MEMORY_TOP_DEFINES_SVH
`define ACCUMULATOR_ALU_WITH_MEMORY_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define AALU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define AALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/aalu_pkg.sv
package aalu_pkg;

   // Datapath width; shift and rotate amounts assume a power of two
   localparam int DATA_WIDTH = 64;
   localparam int AMT_W      = $clog2(DATA_WIDTH);

   // Transaction field widths
   localparam int MODE_W    = 4;
   localparam int OPERAND_W = 64;
   localparam int VALUE_W   = 64;
   localparam int STATUS_W  = 2;

   // Operation codes of the request transaction
   localparam logic [MODE_W-1:0] MODE_LOAD   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_SUB    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_MUL    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_DIV    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_MOD    = 4'd5;
   localparam logic [MODE_W-1:0] MODE_SHL    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_SHR    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_ROTL   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_ROTR   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 4'd10;
   localparam logic [MODE_W-1:0] MODE_SHOW   = 4'd11;
   localparam logic [MODE_W-1:0] MODE_STORE  = 4'd12;
   localparam logic [MODE_W-1:0] MODE_CLRMEM = 4'd13;

   // Status codes of the response transaction
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_HALTED  = 2'd3;

   typedef logic [DATA_WIDTH-1:0] data_type;

   // Operations of the shared arithmetic unit
   typedef enum logic [3:0] {
      UOP_ADD,
      UOP_SUB,
      UOP_MUL,
      UOP_DIV,
      UOP_MOD,
      UOP_SHL,
      UOP_SHR,
      UOP_ROTL,
      UOP_ROTR
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
      logic borrow;
   } unit_sts_type;

endpackage

FILE: hw/rtl/aalu_if.sv
// Request channel: operation, operand and operand select
interface aalu_req_if;
   import aalu_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [OPERAND_W-1:0] operand;
   logic                 use_memory;

   modport source (output valid, output mode, output operand, output use_memory,
                   input ready);
   modport sink   (input valid, input mode, input operand, input use_memory,
                   output ready);
endinterface

// Response channel: accumulator value, status and display flag
interface aalu_rsp_if;
   import aalu_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [STATUS_W-1:0] status;
   logic                shown;

   modport source (output valid, output value, output status, output shown,
                   input ready);
   modport sink   (input valid, input value, input status, input shown,
                   output ready);
endinterface

FILE: hw/rtl/aalu_unit.sv
module aalu_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  aalu_pkg::unit_ctl_type ctl,
   input  aalu_pkg::data_type     a,
   input  aalu_pkg::data_type     b,
   output aalu_pkg::unit_sts_type sts,
   output aalu_pkg::data_type     result
);
   import aalu_pkg::*;

   localparam int DW = DATA_WIDTH;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        borrow_ff, borrow_in;
   unit_op_type op_ff, op_in;
   logic [AMT_W-1:0] count_ff, count_in;
   data_type    x_ff, x_in;
   data_type    y_ff, y_in;
   data_type    r_ff, r_in;

   logic        sub_sel;
   logic [DW:0] add_a;
   logic [DW:0] add_b;
   logic [DW:0] add_s;
   data_type    shift_one;
   logic        last_step;

   // Route the single adder/subtractor to the operation in progress
   always_comb begin
      add_a   = {1'b0, x_ff};
      add_b   = {1'b0, y_ff};
      sub_sel = 1'b0;
      unique case (op_ff)
         UOP_SUB: begin
            sub_sel = 1'b1;
         end
         UOP_MUL: begin
            add_a = {1'b0, r_ff};
            add_b = x_ff[0] ? {1'b0, y_ff} : '0;
         end
         UOP_DIV, UOP_MOD: begin
            add_a   = {r_ff, x_ff[DW-1]};
            sub_sel = 1'b1;
         end
         default: begin
         end
      endcase
      add_s = sub_sel ? (add_a - add_b) : (add_a + add_b);
   end

   // Move the work value by one bit position
   always_comb begin
      unique case (op_ff)
         UOP_SHL:  shift_one = {x_ff[DW-2:0], 1'b0};
         UOP_SHR:  shift_one = {1'b0, x_ff[DW-1:1]};
         UOP_ROTL: shift_one = {x_ff[DW-2:0], x_ff[DW-1]};
         UOP_ROTR: shift_one = {x_ff[0], x_ff[DW-1:1]};
         default:  shift_one = x_ff;
      endcase
   end

   assign last_step = (count_ff == AMT_W'(DW - 1));

   // Load on start, then take one step per cycle until the operation ends
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      borrow_in = borrow_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      r_in      = r_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         op_in     = ctl.op;
         count_in  = '0;
         borrow_in = 1'b0;
         r_in      = '0;
         x_in      = a;
         y_in      = b;
         unique case (ctl.op)
            UOP_MUL: begin
               x_in = b;
               y_in = a;
            end
            UOP_SHL, UOP_SHR, UOP_ROTL, UOP_ROTR: begin
               y_in = DW'(b[AMT_W-1:0]);
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         count_in = count_ff + AMT_W'(1);
         unique case (op_ff)
            UOP_ADD: begin
               r_in    = add_s[DW-1:0];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            UOP_SUB: begin
               r_in      = add_s[DW-1:0];
               borrow_in = add_s[DW];
               busy_in   = 1'b0;
               done_in   = 1'b1;
            end
            UOP_MUL: begin
               r_in = add_s[DW-1:0];
               y_in = {y_ff[DW-2:0], 1'b0};
               x_in = {1'b0, x_ff[DW-1:1]};
               if (last_step) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            UOP_DIV, UOP_MOD: begin
               // Restoring step: keep the trial difference when it does not borrow
               r_in = add_s[DW] ? {r_ff[DW-2:0], x_ff[DW-1]} : add_s[DW-1:0];
               x_in = {x_ff[DW-2:0], ~add_s[DW]};
               if (last_step) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            UOP_SHL, UOP_SHR, UOP_ROTL, UOP_ROTR: begin
               if (y_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  x_in = shift_one;
                  y_in = y_ff - DW'(1);
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      borrow_ff <= borrow_in;
      op_ff     <= op_in;
      count_ff  <= count_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      r_ff      <= r_in;
   end

   // Select the finished value: quotient and shifts live in x, the rest in r
   always_comb begin
      unique case (op_ff)
         UOP_ADD, UOP_SUB, UOP_MUL, UOP_MOD: result = r_ff;
         default:                            result = x_ff;
      endcase
   end

   assign sts.done   = done_ff;
   assign sts.borrow = borrow_ff;

endmodule

FILE: hw/rtl/accumulator_alu_with_memory_top.sv
// Accumulator calculator with one memory register.
// Request channel (req_if): mode, 64-bit operand and use_memory, which takes
// the memory register as operand. Response channel (rsp_if): one transaction
// per request with the accumulator value, a status code and the shown flag.
// Both channels move a transaction when valid and ready are high at a clock
// edge. One request is in work at a time; ready is high only while idle.
// Load, clear, show, store, memory clear, shifts by 64 or more, errors caught
// at decode and requests to a halted block are answered without the unit;
// add, subtract, multiply, divide, modulo, shifts and rotates run on it, and
// shift and rotate move one bit position per step, for the amount mod 64. The
// shared add/subtract/shift unit does one step per cycle: the 64 radix-2
// steps of multiply and divide set the worst case.
// A finished response waits in an output register; the next request is
// taken meanwhile, and a further result waits until the receiver takes it.
// An error (out of range, division by zero) halts the block: later requests
// answer status halted. Synchronous reset clears accumulator, memory, halt
// flag and the response valid.
module accumulator_alu_with_memory_top (
   input logic        clock,
   input logic        reset,
   aalu_req_if.sink   req_if,
   aalu_rsp_if.source rsp_if
);
   import aalu_pkg::*;

   localparam int DW = DATA_WIDTH;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   data_type            acc_ff, acc_in;
   data_type            mem_ff, mem_in;
   logic                halted_ff, halted_in;
   data_type            pend_value_ff, pend_value_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                pend_shown_ff, pend_shown_in;
   logic                rsp_valid_ff, rsp_valid_in;
   data_type            rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_shown_ff, rsp_shown_in;

   unit_ctl_type ctl;
   unit_sts_type sts;
   data_type     unit_result;
   data_type     arg;
   logic         out_free;

   aalu_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .a      (acc_ff),
      .b      (arg),
      .sts    (sts),
      .result (unit_result)
   );

   assign arg      = req_if.use_memory ? mem_ff : req_if.operand[DW-1:0];
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Sequence one transaction: decode, run the unit if the mode needs it, then hand off the result
   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      mem_in         = mem_ff;
      halted_in      = halted_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      pend_shown_in  = pend_shown_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_shown_in   = rsp_shown_ff;
      ctl.start      = 1'b0;
      ctl.op         = UOP_ADD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               state_in       = S_DONE;
               pend_value_in  = acc_ff;
               pend_status_in = STATUS_OK;
               pend_shown_in  = 1'b1;
               if (halted_ff) begin
                  pend_status_in = STATUS_HALTED;
                  pend_shown_in  = 1'b0;
               end else begin
                  unique case (req_if.mode)
                     MODE_LOAD: begin
                        if (arg[DW-1]) begin
                           pend_status_in = STATUS_RANGE;
                           pend_shown_in  = 1'b0;
                           halted_in      = 1'b1;
                        end else begin
                           acc_in        = arg;
                           pend_value_in = arg;
                        end
                     end
                     MODE_ADD: begin
                        ctl.start = 1'b1;
                        ctl.op    = UOP_ADD;
                        state_in  = S_RUN;
                     end
                     MODE_SUB: begin
                        ctl.start = 1'b1;
                        ctl.op    = UOP_SUB;
                        state_in  = S_RUN;
                     end
                     MODE_MUL: begin
                        ctl.start = 1'b1;
                        ctl.op    = UOP_MUL;
                        state_in  = S_RUN;
                     end
                     MODE_DIV, MODE_MOD: begin
                        if (arg == '0) begin
                           pend_status_in = STATUS_DIVZERO;
                           pend_shown_in  = 1'b0;
                           halted_in      = 1'b1;
                        end else begin
                           ctl.start = 1'b1;
                           ctl.op    = (req_if.mode == MODE_DIV) ? UOP_DIV : UOP_MOD;
                           state_in  = S_RUN;
                        end
                     end
                     MODE_SHL, MODE_SHR: begin
                        // Shifts by the full width or more clear the accumulator
                        if (|(arg >> AMT_W)) begin
                           acc_in        = '0;
                           pend_value_in = '0;
                        end else begin
                           ctl.start = 1'b1;
                           ctl.op    = (req_if.mode == MODE_SHL) ? UOP_SHL : UOP_SHR;
                           state_in  = S_RUN;
                        end
                     end
                     MODE_ROTL: begin
                        ctl.start = 1'b1;
                        ctl.op    = UOP_ROTL;
                        state_in  = S_RUN;
                     end
                     MODE_ROTR: begin
                        ctl.start = 1'b1;
                        ctl.op    = UOP_ROTR;
                        state_in  = S_RUN;
                     end
                     MODE_CLEAR: begin
                        acc_in        = '0;
                        pend_value_in = '0;
                     end
                     MODE_SHOW: begin
                     end
                     MODE_STORE: begin
                        mem_in        = acc_ff;
                        pend_shown_in = 1'b0;
                     end
                     MODE_CLRMEM: begin
                        mem_in        = '0;
                        pend_shown_in = 1'b0;
                     end
                     default: begin
                        pend_shown_in = 1'b0;
                     end
                  endcase
               end
            end
         end
         S_RUN: begin
            if (sts.done) begin
               state_in = S_DONE;
               // A subtract that borrows leaves the accumulator and halts
               if (sts.borrow) begin
                  pend_status_in = STATUS_RANGE;
                  pend_shown_in  = 1'b0;
                  halted_in      = 1'b1;
               end else begin
                  acc_in        = unit_result;
                  pend_value_in = unit_result;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               rsp_shown_in  = pend_shown_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         mem_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         mem_ff       <= mem_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      pend_shown_ff  <= pend_shown_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_shown_ff   <= rsp_shown_in;
   end

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = VALUE_W'(rsp_value_ff);
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.shown  = rsp_shown_ff;

endmodule

FILE: hw/rtl/aalu_checker.sv
`include "accumulator_alu_with_memory_top_defines.svh"

module aalu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [aalu_pkg::VALUE_W-1:0]  rsp_value,
   input logic [aalu_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_shown
);
   import aalu_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] open_ff, open_in;
   logic       halted_seen_ff, halted_seen_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Count transactions taken but not yet answered; note a delivered error
   always_comb begin
      open_in        = open_ff + 2'(req_acc) - 2'(rsp_acc);
      halted_seen_in = halted_seen_ff || (rsp_acc && (rsp_status != STATUS_OK));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= '0;
         halted_seen_ff <= 1'b0;
      end else begin
         open_ff        <= open_in;
         halted_seen_ff <= halted_seen_in;
      end
   end

   `AALU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_acc, !req_ready, "ready stayed high after a request")
   `AALU_ASSERT_SAME(a_no_extra_rsp, clock, reset, rsp_valid, open_ff != 2'd0, "response without an open request")
   `AALU_ASSERT_SAME(a_one_in_work, clock, reset, req_acc, (open_ff != 2'd2) && (open_ff != 2'd3), "request taken with two results pending")
   `AALU_ASSERT_SAME(a_stay_halted, clock, reset, rsp_valid && halted_seen_ff, rsp_status == STATUS_HALTED, "response after an error is not halted")
   `AALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_shown), "stalled response changed")

endmodule

bind accumulator_alu_with_memory_top aalu_checker u_aalu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_value  (rsp_if.value),
   .rsp_status (rsp_if.status),
   .rsp_shown  (rsp_if.shown)
);
